### hw/rtl/chte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chte_pkg
// Shared types and constants for the chained hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;

	localparam int KEY_W   = 64;
	localparam int VAL_W   = 32;
	localparam int HASH_W  = 32;   // low key bits that feed the hash
	localparam int DIV_W   = 9;    // bucket_count register width
	localparam int DIGIT_W = 4;    // remainder bits retired per cycle

	localparam int BUCKETS_DEF = 256;
	localparam int NODES_DEF   = 1024;

	localparam logic [DIV_W-1:0] BUCKET_COUNT_RST = 9'd256;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic {
		ST_OK   = 1'b0,
		ST_FULL = 1'b1
	} status_t;

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] result_value;
		status_t          status;
	} res_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_HEAD,
		S_NODE,
		S_RESP
	} state_t;

endpackage
`default_nettype wire

### hw/rtl/chained_hash_table_engine_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_table_engine_unit
// Chained hash table over a fixed node pool with insert and lookup commands.
// ----------------------------------------------------------------------------
// One command is handled at a time. After reset the bucket heads are cleared,
// one bucket a cycle, and no command is taken until every head is cleared;
// configuration writes are taken at any time. The bucket is the low 32 key
// bits modulo the bucket count, computed by a remainder unit that retires 4
// bits a cycle. A lookup reads the chain nodes one after another, since every
// node is a separate read of the node memory that needs the link of the node
// before it. The result sits in an output register, so the next command is
// taken while it waits.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_unit import chte_pkg::*; #(
	parameter int BUCKETS = BUCKETS_DEF,
	parameter int NODES   = NODES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [DIV_W-1:0] cfg_data,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  cmd_t             cmd_data,
	output logic             res_valid,
	input  logic             res_stall,
	output res_t             res_data
);

	localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int PTR_W  = $clog2(NODES + 1);
	localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NODES);

	state_t state_q, state_nx;

	logic [DIV_W-1:0] bucket_count_q;
	logic [DIV_W-1:0] divisor;
	logic [BKT_W-1:0] clr_q;
	logic [BKT_W-1:0] bkt_q;
	logic [PTR_W-1:0] cnt_q;
	cmd_t             cmd_q;
	res_t             rsl_q;
	res_t             res_q;
	logic             res_valid_q;

	logic             div_start;
	logic             div_done;
	logic [DIV_W-1:0] div_rem;

	logic             head_we, head_re;
	logic [BKT_W-1:0] head_waddr, head_raddr;
	logic [PTR_W-1:0] head_wdata, head_rdata;

	logic              node_we, node_re;
	logic [NODE_W-1:0] node_raddr;
	logic [KEY_W-1:0]  node_rkey;
	logic [VAL_W-1:0]  node_rval;
	logic [PTR_W-1:0]  node_rlink;

	logic is_insert;
	logic pool_full;
	logic head_live;
	logic key_hit;
	logic link_live;
	logic res_free;

	assign is_insert = (cmd_q.op == OP_INSERT);
	assign pool_full = (cnt_q == NULL_PTR);
	assign head_live = (head_rdata < cnt_q);
	assign key_hit   = (node_rkey == cmd_q.key);
	assign link_live = (node_rlink < cnt_q);
	assign res_free  = !res_valid_q || !res_stall;

	// zero counts as one, anything past the table size saturates
	always_comb begin
		divisor = bucket_count_q;
		if (bucket_count_q == '0) begin
			divisor = DIV_W'(1);
		end else if (32'(bucket_count_q) > 32'(BUCKETS)) begin
			divisor = DIV_W'(BUCKETS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_COUNT_RST;
		end else if (cfg_valid) begin
			bucket_count_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == BKT_W'(BUCKETS - 1)) state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (cmd_valid) state_nx = S_HASH;
			end
			S_HASH: begin
				if (div_done) state_nx = S_HEAD;
			end
			S_HEAD: begin
				if (!is_insert && head_live) state_nx = S_NODE;
				else state_nx = S_RESP;
			end
			S_NODE: begin
				if (key_hit || !link_live) state_nx = S_RESP;
			end
			S_RESP: begin
				if (res_free) state_nx = S_IDLE;
			end
			default: state_nx = S_CLEAR;
		endcase
	end

	// control outputs
	always_comb begin
		cmd_stall  = 1'b1;
		div_start  = 1'b0;
		head_we    = 1'b0;
		head_waddr = bkt_q;
		head_wdata = cnt_q;
		head_re    = 1'b0;
		head_raddr = BKT_W'(div_rem);
		node_we    = 1'b0;
		node_re    = 1'b0;
		node_raddr = NODE_W'(node_rlink);
		unique case (state_q)
			S_CLEAR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
				head_wdata = NULL_PTR;
			end
			S_IDLE: begin
				cmd_stall = 1'b0;
				div_start = cmd_valid;
			end
			S_HASH: begin
				head_re = div_done;
			end
			S_HEAD: begin
				if (is_insert) begin
					node_we = !pool_full;
					head_we = !pool_full;
				end else begin
					node_re    = head_live;
					node_raddr = NODE_W'(head_rdata);
				end
			end
			S_NODE: begin
				node_re = !key_hit && link_live;
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + BKT_W'(1);
			end
			if (state_q == S_HEAD && is_insert && !pool_full) begin
				cnt_q <= cnt_q + PTR_W'(1);
			end
			if (state_q == S_RESP && res_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) begin
			cmd_q <= cmd_data;
		end
		if (state_q == S_HASH && div_done) begin
			bkt_q <= BKT_W'(div_rem);
		end
		if (state_q == S_HEAD) begin
			rsl_q <= '{found: 1'b0, result_value: '0,
				status: (is_insert && pool_full) ? ST_FULL : ST_OK};
		end
		if (state_q == S_NODE && key_hit) begin
			rsl_q.found        <= 1'b1;
			rsl_q.result_value <= node_rval;
		end
		if (state_q == S_RESP && res_free) begin
			res_q <= rsl_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	chte_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (cmd_data.key[HASH_W-1:0]),
		.divisor   (divisor),
		.done      (div_done),
		.remainder (div_rem)
	);

	chte_head_ram #(
		.BUCKETS (BUCKETS),
		.NODES   (NODES)
	) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.re    (head_re),
		.raddr (head_raddr),
		.rdata (head_rdata)
	);

	// new node links to the old head and becomes the head itself
	chte_node_ram #(
		.NODES (NODES)
	) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (NODE_W'(cnt_q)),
		.wkey  (cmd_q.key),
		.wval  (cmd_q.value),
		.wlink (head_rdata),
		.re    (node_re),
		.raddr (node_raddr),
		.rkey  (node_rkey),
		.rval  (node_rval),
		.rlink (node_rlink)
	);

endmodule
`default_nettype wire

### hw/rtl/chte_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chte_mod
// Iterative remainder unit: restoring division, DIGIT_W quotient bits a cycle.
// ----------------------------------------------------------------------------
module chte_mod import chte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HASH_W-1:0] dividend,
	input  logic [DIV_W-1:0]  divisor,
	output logic              done,
	output logic [DIV_W-1:0]  remainder
);

	localparam int STEPS = HASH_W / DIGIT_W;
	localparam int CNT_W = $clog2(STEPS);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [HASH_W-1:0] dvd_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  rem_nx;
	logic [DIV_W:0]    trial;

	always_comb begin
		rem_nx = rem_q;
		trial  = '0;
		for (int i = 0; i < DIGIT_W; i++) begin
			trial = {rem_nx, dvd_q[HASH_W-1-i]};
			if (trial >= {1'b0, divisor}) begin
				trial = trial - {1'b0, divisor};
			end
			rem_nx = trial[DIV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << DIGIT_W;
			rem_q <= rem_nx;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

### hw/rtl/chte_head_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chte_head_ram
// Bucket head pointers: one write port, one registered read port.
// ----------------------------------------------------------------------------
module chte_head_ram import chte_pkg::*; #(
	parameter int BUCKETS = BUCKETS_DEF,
	parameter int NODES   = NODES_DEF,
	localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
	localparam int PTR_W  = $clog2(NODES + 1)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [BKT_W-1:0] waddr,
	input  logic [PTR_W-1:0] wdata,
	input  logic             re,
	input  logic [BKT_W-1:0] raddr,
	output logic [PTR_W-1:0] rdata
);

	logic [PTR_W-1:0] mem [BUCKETS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### hw/rtl/chte_node_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chte_node_ram
// Node pool: key, value and link per node, one write and one read port.
// ----------------------------------------------------------------------------
module chte_node_ram import chte_pkg::*; #(
	parameter int NODES   = NODES_DEF,
	localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1,
	localparam int PTR_W  = $clog2(NODES + 1)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [NODE_W-1:0] waddr,
	input  logic [KEY_W-1:0]  wkey,
	input  logic [VAL_W-1:0]  wval,
	input  logic [PTR_W-1:0]  wlink,
	input  logic              re,
	input  logic [NODE_W-1:0] raddr,
	output logic [KEY_W-1:0]  rkey,
	output logic [VAL_W-1:0]  rval,
	output logic [PTR_W-1:0]  rlink
);

	localparam int ENT_W = KEY_W + VAL_W + PTR_W;

	logic [ENT_W-1:0] mem [NODES];
	logic [ENT_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wkey, wval, wlink};
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rkey  = rd_q[ENT_W-1 -: KEY_W];
	assign rval  = rd_q[PTR_W +: VAL_W];
	assign rlink = rd_q[PTR_W-1:0];

endmodule
`default_nettype wire
